FILE: hw/rtl/rcf_pkg.sv
package rcf_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} req_t;

	typedef struct packed {
		logic        request_done;
		logic [31:0] request_length;
		logic        length_known;
		logic [31:0] total_bytes;
		logic        length_overflow;
	} rsp_t;

	typedef enum logic [3:0] {
		PH_SEARCH = 4'b0001,
		PH_LEAD   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0]  end_match;
		logic        header_done;
		logic [3:0]  field_match;
		phase_t      phase;
		logic        negative;
		logic [31:0] content;
	} http_state_t;

	localparam logic [3:0] FIELD_LEN = 4'd15;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;

	localparam http_state_t HTTP_STATE_CLEAR = '{
		end_match:   2'd0,
		header_done: 1'b0,
		field_match: 4'd0,
		phase:       PH_SEARCH,
		negative:    1'b0,
		content:     32'd0
	};

	function automatic logic [7:0] field_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "L";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			4'd14:   c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] end_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0:    c = 8'h0d;
			2'd1:    c = 8'h0a;
			2'd2:    c = 8'h0d;
			default: c = 8'h0a;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/rcf_http_step.sv
module rcf_http_step #(
	parameter int COUNT_BITS = 32
) (
	input  logic [7:0]            data_byte,
	input  logic [COUNT_BITS-1:0] byte_count,
	input  logic                  overflow_in,
	input  rcf_pkg::http_state_t  cur,
	output rcf_pkg::http_state_t  nxt,
	output logic                  total_set,
	output logic [COUNT_BITS-1:0] total,
	output logic                  overflow_out
);

	localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

	logic        digit;
	logic        blank;
	logic        sign;
	logic [3:0]  digit_val;
	logic [35:0] prod;
	logic        prod_sat;
	logic [3:0]  fm;
	logic [31:0] cv;
	logic [32:0] sum;

	assign digit     = (data_byte >= rcf_pkg::CH_0) && (data_byte <= rcf_pkg::CH_9);
	assign blank     = (data_byte == rcf_pkg::CH_SPACE) ||
		((data_byte >= rcf_pkg::CH_TAB) && (data_byte <= rcf_pkg::CH_CR));
	assign sign      = (data_byte == rcf_pkg::CH_PLUS) || (data_byte == rcf_pkg::CH_MINUS);
	assign digit_val = 4'(data_byte - rcf_pkg::CH_0);
	assign prod      = ({4'd0, cur.content} << 3) + ({4'd0, cur.content} << 1) +
		36'(digit_val);
	assign prod_sat  = (prod[35:32] != 4'd0);

	always_comb begin
		nxt          = cur;
		total_set    = 1'b0;
		total        = '0;
		overflow_out = overflow_in;
		fm           = 4'd0;
		cv           = cur.content;
		sum          = 33'd0;
		if (!cur.header_done) begin
			if ((cur.phase == rcf_pkg::PH_LEAD) || (cur.phase == rcf_pkg::PH_DIGITS)) begin
				if (digit) begin
					if (prod_sat) begin
						nxt.content  = '1;
						overflow_out = 1'b1;
					end else begin
						nxt.content = prod[31:0];
					end
					nxt.phase = rcf_pkg::PH_DIGITS;
				end else if ((cur.phase == rcf_pkg::PH_LEAD) && sign) begin
					nxt.negative = (data_byte == rcf_pkg::CH_MINUS);
					nxt.phase    = rcf_pkg::PH_DIGITS;
				end else if (!((cur.phase == rcf_pkg::PH_LEAD) && blank)) begin
					nxt.phase = rcf_pkg::PH_DONE;
				end
			end

			if (nxt.phase == rcf_pkg::PH_SEARCH) begin
				if ((cur.field_match < rcf_pkg::FIELD_LEN) &&
					(data_byte == rcf_pkg::field_char(cur.field_match))) begin
					fm = cur.field_match + 4'd1;
				end else begin
					fm = (data_byte == rcf_pkg::field_char(4'd0)) ? 4'd1 : 4'd0;
				end
				if (fm == rcf_pkg::FIELD_LEN) begin
					nxt.phase = rcf_pkg::PH_LEAD;
					fm        = 4'd0;
				end
				nxt.field_match = fm;
			end

			if (data_byte == rcf_pkg::end_char(cur.end_match)) begin
				if (cur.end_match == 2'd3) begin
					nxt.header_done = 1'b1;
					nxt.end_match   = 2'd0;
					total_set       = 1'b1;
					if (nxt.phase == rcf_pkg::PH_SEARCH) begin
						total = byte_count;
					end else begin
						if (cur.negative && !overflow_out) begin
							cv = ~cur.content + 32'd1;
						end
						sum = 33'(byte_count) + 33'(cv);
						if (sum > COUNT_MAX) begin
							total        = '1;
							overflow_out = 1'b1;
						end else begin
							total = sum[COUNT_BITS-1:0];
						end
					end
				end else begin
					nxt.end_match = cur.end_match + 2'd1;
				end
			end else begin
				nxt.end_match = (data_byte == rcf_pkg::CH_CR) ? 2'd1 : 2'd0;
			end
		end
	end

endmodule

FILE: hw/rtl/request_completion_framer.sv
// Request completion framer: watches the bytes of a request, one per transaction on the
// req channel, and reports on the rsp channel for every byte whether it completes the request.
// In HTTP mode the request ends at the header end (CR LF CR LF) plus the Content-Length value;
// in prefix mode the first two bytes give a big-endian length, and the total is that plus two.
// The user must write the mode (cfg_we, cfg_wdata) only while idle; the block does not check.
// Both channels use valid and stall; a transaction completes at a clock edge with valid high
// and stall low. Every req transaction produces exactly one rsp transaction.
// A byte taken at an edge sits in the input register, is framed by combinational logic and
// lands in the result register once that register is empty or rsp_stall is low, to be offered.
// The framing state is updated at that same edge, so one byte per cycle is sustained while
// rsp_stall is low; the per-byte loop through the state registers sets that rate.
// When rsp_stall is high the result register holds, the input register holds its byte and
// req_stall rises once the input register is occupied.
// Reset clears the pipeline, the mode (HTTP) and all request state. After a completing byte
// the next byte starts a new request; a byte with restart set starts a new request itself.
module request_completion_framer #(
	parameter int COUNT_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rcf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rcf_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);

	localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

	logic                  mode_q;
	logic                  valid_s1;
	rcf_pkg::req_t         req_s1;
	logic                  valid_s2;
	rcf_pkg::rsp_t         rsp_s2;

	logic [COUNT_BITS-1:0] bc_q;
	rcf_pkg::http_state_t  hs_q;
	logic [COUNT_BITS-1:0] total_q;
	logic                  known_q;
	logic [7:0]            phb_q;
	logic                  ovf_q;

	logic                  s1_move;
	logic                  s1_load;

	logic [COUNT_BITS-1:0] bc_eff;
	rcf_pkg::http_state_t  hs_eff;
	logic [COUNT_BITS-1:0] total_eff;
	logic                  known_eff;
	logic [7:0]            phb_eff;
	logic                  ovf_eff;

	logic                  bc_sat;
	logic [COUNT_BITS-1:0] bc_new;
	logic                  ovf_a;

	rcf_pkg::http_state_t  hs_step;
	logic                  http_total_set;
	logic [COUNT_BITS-1:0] http_total;
	logic                  http_ovf;

	logic [32:0]           prefix_total;

	rcf_pkg::http_state_t  hs_n;
	logic [COUNT_BITS-1:0] total_n;
	logic                  known_n;
	logic [7:0]            phb_n;
	logic                  ovf_n;
	logic                  done;
	rcf_pkg::rsp_t         rsp_n;

	assign s1_move   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !s1_move;
	assign s1_load   = req_valid && !req_stall;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			req_s1 <= req;
		end
		if (s1_move) begin
			rsp_s2 <= rsp_n;
		end
	end

	always_comb begin
		if (req_s1.restart) begin
			bc_eff    = '0;
			hs_eff    = rcf_pkg::HTTP_STATE_CLEAR;
			total_eff = '0;
			known_eff = 1'b0;
			phb_eff   = 8'd0;
			ovf_eff   = 1'b0;
		end else begin
			bc_eff    = bc_q;
			hs_eff    = hs_q;
			total_eff = total_q;
			known_eff = known_q;
			phb_eff   = phb_q;
			ovf_eff   = ovf_q;
		end
	end

	assign bc_sat = (bc_eff == '1);
	assign bc_new = bc_sat ? bc_eff : bc_eff + 1'b1;
	assign ovf_a  = ovf_eff || bc_sat;

	rcf_http_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_http (
		.data_byte   (req_s1.data_byte),
		.byte_count  (bc_new),
		.overflow_in (ovf_a),
		.cur         (hs_eff),
		.nxt         (hs_step),
		.total_set   (http_total_set),
		.total       (http_total),
		.overflow_out(http_ovf)
	);

	assign prefix_total = 33'({phb_eff, req_s1.data_byte}) + 33'd2;

	always_comb begin
		hs_n    = hs_eff;
		total_n = total_eff;
		known_n = known_eff;
		phb_n   = phb_eff;
		ovf_n   = ovf_a;
		if (!mode_q) begin
			hs_n  = hs_step;
			ovf_n = http_ovf;
			if (http_total_set) begin
				total_n = http_total;
				known_n = 1'b1;
			end
		end else if (!known_eff) begin
			if (bc_new == COUNT_BITS'(1)) begin
				phb_n = req_s1.data_byte;
			end else if (bc_new >= COUNT_BITS'(2)) begin
				known_n = 1'b1;
				if (prefix_total > COUNT_MAX) begin
					total_n = '1;
					ovf_n   = 1'b1;
				end else begin
					total_n = prefix_total[COUNT_BITS-1:0];
				end
			end
		end
	end

	assign done = known_n && (bc_new >= total_n);

	always_comb begin
		rsp_n.request_done    = done;
		rsp_n.request_length  = 32'(bc_new);
		rsp_n.length_known    = known_n;
		rsp_n.total_bytes     = known_n ? 32'(total_n) : 32'd0;
		rsp_n.length_overflow = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q    <= '0;
			hs_q    <= rcf_pkg::HTTP_STATE_CLEAR;
			total_q <= '0;
			known_q <= 1'b0;
			phb_q   <= 8'd0;
			ovf_q   <= 1'b0;
		end else if (s1_move) begin
			if (done) begin
				bc_q    <= '0;
				hs_q    <= rcf_pkg::HTTP_STATE_CLEAR;
				total_q <= '0;
				known_q <= 1'b0;
				phb_q   <= 8'd0;
				ovf_q   <= 1'b0;
			end else begin
				bc_q    <= bc_new;
				hs_q    <= hs_n;
				total_q <= total_n;
				known_q <= known_n;
				phb_q   <= phb_n;
				ovf_q   <= ovf_n;
			end
		end
	end

	a_done_known: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.request_done |-> rsp.length_known)
		else $error("completion reported without a known length");

	a_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.length_known |-> rsp.total_bytes == 32'd0)
		else $error("total length nonzero while unknown");

	a_clear_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && done |=> bc_q == '0 && !known_q && !ovf_q)
		else $error("request state not cleared after completion");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with room in the pipeline");

endmodule
